[design/tle_pkg.sv]
// Shared types and constants for the terminal line editor.
// No dependencies; terminal_line_editor, tle_ctrl and tle_dp import this package.
`default_nettype none

package tle_pkg;

    // Line capacity after reset
    localparam logic [5:0] CAP_RESET = 6'd32;

    // Byte codes
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Echo ROM layout
    localparam logic [4:0] R_ERASE_B = 5'd0;
    localparam logic [4:0] R_ERASE_E = 5'd3;
    localparam logic [4:0] R_MOVE_B  = 5'd4;
    localparam logic [4:0] R_TENS    = 5'd6;
    localparam logic [4:0] R_UNITS   = 5'd7;
    localparam logic [4:0] R_MOVE_E  = 5'd12;
    localparam logic [4:0] R_NL_B    = 5'd13;
    localparam logic [4:0] R_NL_E    = 5'd14;
    localparam logic [4:0] R_RIGHT_B = 5'd15;
    localparam logic [4:0] R_RIGHT_E = 5'd17;
    localparam logic [4:0] R_LEFT_B  = 5'd18;
    localparam logic [4:0] R_LEFT_E  = 5'd20;
    localparam logic [4:0] R_RX      = 5'd21;

    // Line update applied when a byte is accepted
    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_BACK,
        OP_RIGHT,
        OP_LEFT
    } t_op;

    // Source of an emitted result
    typedef enum logic [1:0] {
        SRC_ROM,
        SRC_CHAR,
        SRC_DONE
    } t_src;

    typedef struct packed {
        logic       accept;
        t_op        op;
        logic       emit;
        t_src       src;
        logic [4:0] rom_idx;
        logic       last;
        logic       drain_step;
        logic       line_clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic len_zero;
        logic cur_eq_len;
        logic cur_lt_len;
        logic cur_nz;
        logic drain_last;
        logic out_free;
    } t_sts;

    // Echo sequences; digit and received-byte slots are filled by the datapath
    function automatic logic [7:0] echo_rom(input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = CH_BS;
            5'd1:    b = CH_ESC;
            5'd2:    b = CH_LBR;
            5'd3:    b = CH_K;
            5'd4:    b = CH_ESC;
            5'd5:    b = CH_LBR;
            5'd8:    b = CH_C;
            5'd9:    b = CH_BS;
            5'd10:   b = CH_ESC;
            5'd11:   b = CH_LBR;
            5'd12:   b = CH_K;
            5'd13:   b = CH_LF;
            5'd14:   b = CH_CR;
            5'd15:   b = CH_ESC;
            5'd16:   b = CH_LBR;
            5'd17:   b = CH_C;
            5'd18:   b = CH_ESC;
            5'd19:   b = CH_LBR;
            5'd20:   b = CH_D;
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[design/tle_if.sv]
// Channel interfaces of the terminal line editor: input bytes, results, config.
// No dependencies.
`default_nettype none

interface tle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [4:0] line_length;
    logic       last;
    modport source (output valid, output kind, output out_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input line_length,
                    input last, output ready);
endinterface

interface tle_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] line_capacity;
    modport source (output valid, output line_capacity, input ready);
    modport sink   (input valid, input line_capacity, output ready);
endinterface

`default_nettype wire

[design/terminal_line_editor.sv]
// Terminal line editor. Each received byte is accepted and then produces its
// results, one word per cycle on the result channel while the result side
// does not stall; the next byte is taken only once all results of the last
// one are issued. Some bytes (escape bytes, a no-op backspace or arrow) give
// no result. The single result register carries the words; the line store is
// read one character per cycle, unless the result side stalls, through a
// prefetched registered port.
// The result register lets the next byte be accepted while the last word of the
// previous one still waits. Capacity is written through the config channel,
// which is always ready; write it only while the block is idle.
// Depends on tle_pkg, tle_if, tle_ctrl and tle_dp.
`default_nettype none

module terminal_line_editor
    import tle_pkg::*;
#(
    // Depth of the line store; a line holds at most LINE_DEPTH - 1 characters
    parameter int LINE_DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tle_in_if.sink     i_rx,
    tle_out_if.source  o_res,
    tle_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // The config channel is always ready
    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = in_ready;

    // Controller: byte decode, escape tracking, result sequencing
    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .i_rx_byte  (i_rx.rx_byte),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: line store, cursor/length, digits, result register
    tle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_data    (i_cfg.line_capacity),
        .i_rx_byte     (i_rx.rx_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_kind        (o_res.kind),
        .o_out_byte    (o_res.out_byte),
        .o_line_length (o_res.line_length),
        .o_last        (o_res.last)
    );

endmodule

`default_nettype wire

[design/tle_ctrl.sv]
// Controller: decodes each byte, tracks escape sequences, sequences the results.
// Depends on tle_pkg.
`default_nettype none

module tle_ctrl
    import tle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_in_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_OPEN,
        E_SKIP,
        E_LETTER,
        E_TAIL
    } t_esc;

    t_state     r_state;
    t_esc       r_esc;
    logic       r_zero_form;
    logic [7:0] r_letter;
    logic [4:0] r_idx;
    logic [4:0] r_end;
    logic       r_close;

    t_esc       n_esc;
    logic       n_zero_form;
    logic [7:0] n_letter;

    logic       accept;
    logic       act;
    logic [7:0] letter;
    logic       p_echo;
    logic [4:0] p_beg;
    logic [4:0] p_end;
    logic       p_close;
    t_op        p_op;
    logic       erase;
    logic       move;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Plan for the byte on the input
    always_comb begin
        n_esc       = r_esc;
        n_zero_form = r_zero_form;
        n_letter    = r_letter;
        act         = 1'b0;
        letter      = r_letter;
        p_echo      = 1'b0;
        p_beg       = R_RX;
        p_end       = R_RX;
        p_close     = 1'b0;
        p_op        = OP_NONE;
        erase       = i_sts.cur_eq_len && !i_sts.len_zero;
        move        = !i_sts.full && !i_sts.len_zero;
        if (r_esc != E_IDLE) begin
            unique case (r_esc)
                E_OPEN: begin
                    n_zero_form = (i_rx_byte == CH_NUL);
                    n_esc       = (i_rx_byte == CH_NUL) ? E_SKIP : E_LETTER;
                end
                E_SKIP: begin
                    n_esc = E_LETTER;
                end
                E_LETTER: begin
                    n_letter = i_rx_byte;
                    letter   = i_rx_byte;
                    if (r_zero_form) begin
                        n_esc = E_TAIL;
                    end else begin
                        n_esc = E_IDLE;
                        act   = 1'b1;
                    end
                end
                E_IDLE, E_TAIL: begin
                    n_esc = E_IDLE;
                    act   = 1'b1;
                end
            endcase
            if (act) begin
                priority if (letter == CH_C && i_sts.cur_lt_len) begin
                    p_echo = 1'b1;
                    p_beg  = R_RIGHT_B;
                    p_end  = R_RIGHT_E;
                    p_op   = OP_RIGHT;
                end else if (letter == CH_D && i_sts.cur_nz) begin
                    p_echo = 1'b1;
                    p_beg  = R_LEFT_B;
                    p_end  = R_LEFT_E;
                    p_op   = OP_LEFT;
                end else begin
                    p_echo = 1'b0;
                end
            end
        end else begin
            priority if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                p_echo  = erase || move;
                p_beg   = erase ? R_ERASE_B : R_MOVE_B;
                p_end   = move ? R_MOVE_E : R_ERASE_E;
                p_op    = move ? OP_BACK : OP_NONE;
                p_close = i_sts.full;
            end else if (i_rx_byte == CH_LF || i_rx_byte == CH_CR) begin
                p_echo  = 1'b1;
                p_beg   = R_NL_B;
                p_end   = R_NL_E;
                p_close = 1'b1;
            end else if (i_rx_byte == CH_ESC) begin
                p_close = i_sts.full;
                n_esc   = i_sts.full ? E_IDLE : E_OPEN;
            end else begin
                p_echo  = 1'b1;
                p_close = i_sts.full;
                p_op    = i_sts.full ? OP_NONE : OP_WRITE;
            end
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.op         = accept ? p_op : OP_NONE;
        o_cmd.src        = SRC_ROM;
        o_cmd.rom_idx    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.emit = 1'b0;
            end
            S_ECHO: begin
                o_cmd.emit = i_sts.out_free;
                o_cmd.last = (r_idx == r_end) && !r_close;
            end
            S_DRAIN: begin
                o_cmd.emit       = i_sts.out_free;
                o_cmd.src        = SRC_CHAR;
                o_cmd.drain_step = i_sts.out_free && !i_sts.drain_last;
            end
            S_DONE: begin
                o_cmd.emit       = i_sts.out_free;
                o_cmd.src        = SRC_DONE;
                o_cmd.last       = 1'b1;
                o_cmd.line_clear = i_sts.out_free;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_esc       <= E_IDLE;
            r_zero_form <= 1'b0;
            r_letter    <= CH_NUL;
            r_idx       <= R_RX;
            r_end       <= R_RX;
            r_close     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_esc       <= n_esc;
                        r_zero_form <= n_zero_form;
                        r_letter    <= n_letter;
                        r_idx       <= p_beg;
                        r_end       <= p_end;
                        r_close     <= p_close;
                        if (p_echo) begin
                            r_state <= S_ECHO;
                        end else if (p_close) begin
                            r_state <= i_sts.len_zero ? S_DONE : S_DRAIN;
                        end
                    end
                end
                S_ECHO: begin
                    if (i_sts.out_free) begin
                        if (r_idx == r_end) begin
                            if (r_close) begin
                                r_state <= i_sts.len_zero ? S_DONE : S_DRAIN;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (i_sts.out_free && i_sts.drain_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !i_sts.len_zero)
        else $error("draining an empty line");

    a_echo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ECHO) |-> (r_idx <= r_end))
        else $error("echo index ran past its sequence");

endmodule

`default_nettype wire

[design/tle_dp.sv]
// Datapath: line store, cursor, length, capacity register and result register.
// Depends on tle_pkg.
`default_nettype none

module tle_dp
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [5:0] i_cfg_data,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic [4:0]      o_line_length,
    output logic            o_last
);

    localparam int LW = $clog2(LINE_DEPTH);
    localparam int CW = ($clog2(LINE_DEPTH + 1) > 6) ? $clog2(LINE_DEPTH + 1) : 6;

    logic [7:0]    r_store [LINE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [5:0]    r_cap;
    logic [LW-1:0] r_cursor;
    logic [LW-1:0] r_length;
    logic [LW-1:0] r_cnt;
    logic [3:0]    r_tens;
    logic [3:0]    r_units;
    logic [7:0]    r_rx;
    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_out_byte;
    logic [4:0]    r_line_length;
    logic          r_last;

    logic [CW-1:0] eff_cap;
    logic [CW-1:0] max_chars;
    logic [LW-1:0] diff;
    logic [15:0]   prod;
    logic [3:0]    tens;
    logic [3:0]    units;
    logic [LW:0]   cnt_inc;
    logic [LW-1:0] rd_addr;
    logic [LW-1:0] cur_inc;
    logic [LW-1:0] len_dec;
    logic          out_free;
    logic [7:0]    rom_byte;
    logic [7:0]    emit_byte;

    assign eff_cap   = (CW'(r_cap) > CW'(LINE_DEPTH)) ? CW'(LINE_DEPTH) : CW'(r_cap);
    assign max_chars = (eff_cap == '0) ? '0 : eff_cap - CW'(1);

    // Decimal digits of length - cursor (below 100): reciprocal multiply by 205/2048
    assign diff  = r_length - r_cursor;
    assign prod  = 16'(diff) * 16'd205;
    assign tens  = 4'(prod >> 11);
    assign units = 4'(16'(diff) - 16'(tens) * 16'd10);

    assign cnt_inc  = {1'b0, r_cnt} + (LW+1)'(1);
    assign cur_inc  = r_cursor + LW'(1);
    assign len_dec  = r_length - LW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    // Prefetch the next line character so drain runs one per cycle while the result register is free
    always_comb begin
        priority if (i_cmd.accept) begin
            rd_addr = '0;
        end else if (i_cmd.drain_step) begin
            rd_addr = cnt_inc[LW-1:0];
        end else begin
            rd_addr = r_cnt;
        end
    end

    always_comb begin
        o_sts.full       = CW'(r_length) >= max_chars;
        o_sts.len_zero   = (r_length == '0);
        o_sts.cur_eq_len = (r_cursor == r_length);
        o_sts.cur_lt_len = (r_cursor < r_length);
        o_sts.cur_nz     = (r_cursor != '0);
        o_sts.drain_last = (cnt_inc == {1'b0, r_length});
        o_sts.out_free   = out_free;
    end

    always_comb begin
        priority if (i_cmd.rom_idx == R_TENS) begin
            rom_byte = CH_ZERO + {4'd0, r_tens};
        end else if (i_cmd.rom_idx == R_UNITS) begin
            rom_byte = CH_ZERO + {4'd0, r_units};
        end else if (i_cmd.rom_idx == R_RX) begin
            rom_byte = r_rx;
        end else begin
            rom_byte = echo_rom(i_cmd.rom_idx);
        end
    end

    always_comb begin
        unique case (i_cmd.src)
            SRC_ROM:  emit_byte = rom_byte;
            SRC_CHAR: emit_byte = r_rd_data;
            default:  emit_byte = CH_NUL;
        endcase
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_cmd.op == OP_WRITE) begin
            r_store[r_cursor] <= i_rx_byte;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_cursor    <= '0;
            r_length    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_cnt <= '0;
                unique case (i_cmd.op)
                    OP_WRITE: begin
                        r_cursor <= cur_inc;
                        if (cur_inc > r_length) begin
                            r_length <= cur_inc;
                        end
                    end
                    OP_BACK: begin
                        r_length <= len_dec;
                        r_cursor <= len_dec;
                    end
                    OP_RIGHT: r_cursor <= cur_inc;
                    OP_LEFT:  r_cursor <= r_cursor - LW'(1);
                    default:  r_cursor <= r_cursor;
                endcase
            end else if (i_cmd.drain_step) begin
                r_cnt <= cnt_inc[LW-1:0];
            end
            if (i_cmd.line_clear) begin
                r_cursor <= '0;
                r_length <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rx    <= i_rx_byte;
            r_tens  <= tens;
            r_units <= units;
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.src)
                SRC_ROM:  r_kind <= KIND_ECHO;
                SRC_CHAR: r_kind <= KIND_CHAR;
                default:  r_kind <= KIND_DONE;
            endcase
            r_out_byte    <= emit_byte;
            r_line_length <= (i_cmd.src == SRC_DONE) ? 5'(r_length) : 5'd0;
            r_last        <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_out_byte;
    assign o_line_length = r_line_length;
    assign o_last        = r_last;

    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_length)
        else $error("cursor beyond line end");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.src == SRC_DONE) |=> (r_length == '0 && r_cursor == '0))
        else $error("line not cleared after completion");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
